FILE: hw/rtl/trs_pkg.sv
// Package for the relay schedule sequencer: request/response payloads,
// command and status codes, row layout and shared constants. No dependencies.
package trs_pkg;

    localparam int MAX_ROWS_DEF    = 64;
    localparam int RELAY_COUNT_DEF = 5;
    localparam int RELAY_MAX       = 5;
    localparam int CHANCE_W        = 17;
    localparam logic [31:0] LFSR_TAPS   = 32'h8020_0003;
    localparam logic [32:0] CHANCE_SPAN = 33'((100 * 1000) + 1);

    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_START = 3'd1,
        CMD_TICK  = 3'd2,
        CMD_PAUSE = 3'd3,
        CMD_STOP  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_STOPPED = 2'd0,
        ST_RUNNING = 2'd1,
        ST_PAUSED  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RM_ON        = 2'd0,
        RM_OFF       = 2'd1,
        RM_RANDOM    = 2'd2,
        RM_UNCHANGED = 2'd3
    } relay_mode_t;

    typedef enum logic [1:0] {
        REG_RUN_MODE    = 2'd0,
        REG_RUN_COUNT   = 2'd1,
        REG_ROW_COUNT   = 2'd2,
        REG_RANDOM_SEED = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]          command;
        logic [5:0]          row_index;
        logic                time_mode;
        logic [31:0]         time_low;
        logic [31:0]         time_high;
        logic [9:0]          relay_modes;
        logic [CHANCE_W-1:0] chance_0;
        logic [CHANCE_W-1:0] chance_1;
        logic [CHANCE_W-1:0] chance_2;
        logic [CHANCE_W-1:0] chance_3;
        logic [CHANCE_W-1:0] chance_4;
    } req_t;

    typedef struct packed {
        logic [RELAY_MAX-1:0] relay_levels;
        logic [1:0]           status;
        logic [5:0]           row_number;
        logic [31:0]          run_number;
        logic                 row_started;
    } rsp_t;

    typedef struct packed {
        logic [31:0]                       time_low;
        logic [31:0]                       time_high;
        logic [9:0]                        relay_modes;
        logic                              time_mode;
        logic [RELAY_MAX-1:0][CHANCE_W-1:0] chances;
    } row_t;

    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        logic [31:0] s;
        s = v >> 1;
        if (v[0])
        begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/trs_req_if.sv
// Request channel of the relay sequencer.
// Depends on trs_pkg for the payload type.
interface trs_req_if;
    logic          valid;
    logic          ready;
    trs_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/trs_rsp_if.sv
// Response channel of the relay sequencer.
// Depends on trs_pkg for the payload type.
interface trs_rsp_if;
    logic          valid;
    logic          ready;
    trs_pkg::rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/timed_relay_sequencer.sv
// Relay schedule sequencer top level.
// A row change makes each random draw through the shared remainder unit (up to six
// draws), and a stalled response holds the block further. One request at a time.
// Reset clears status, relays, row, pass and dwell and sets the LFSR to 1; the row
// memory holds nothing defined until loaded.
module timed_relay_sequencer
#(
    parameter int MAX_ROWS    = trs_pkg::MAX_ROWS_DEF,
    parameter int RELAY_COUNT = trs_pkg::RELAY_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    trs_req_if.sink     req,
    trs_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int ADDR_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ZW     = 3;

    typedef enum logic [2:0] {
        S_IDLE, S_ADVANCE, S_READ, S_RELAY, S_WAIT_R, S_TIME, S_WAIT_T, S_FINISH
    } state_t;

    state_t                 state_reg;
    logic                   run_mode_reg;
    logic [31:0]            run_count_reg;
    logic [6:0]             row_count_reg;
    logic [31:0]            seed_reg;
    logic [1:0]             status_reg;
    logic [RELAY_COUNT-1:0] relay_reg;
    logic [ADDR_W-1:0]      active_reg;
    logic [ADDR_W-1:0]      row_sel_reg;
    logic [31:0]            pass_reg;
    logic [31:0]            wait_reg;
    logic [31:0]            lfsr_reg;
    logic [ZW-1:0]          z_reg;
    logic                   started_reg;
    logic                   rsp_valid_reg;
    trs_pkg::rsp_t          rsp_reg;

    logic                   cfg_wr;
    logic                   req_fire;
    logic                   mem_wr;
    trs_pkg::row_t          wr_row;
    trs_pkg::row_t          row;
    logic [31:0]            rows_use;
    logic [ADDR_W:0]        next_row;
    logic [31:0]            pass_inc;
    logic [1:0]             cur_mode;
    logic [31:0]            draw;
    logic [31:0]            hi_eff;
    logic                   mod_start;
    logic [31:0]            mod_dividend;
    logic [32:0]            mod_divisor;
    logic                   mod_done;
    logic [31:0]            mod_rem;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (trs_pkg::reg_idx_t'(paddr[3:2]))
            trs_pkg::REG_RUN_MODE:    prdata = {31'd0, run_mode_reg};
            trs_pkg::REG_RUN_COUNT:   prdata = run_count_reg;
            trs_pkg::REG_ROW_COUNT:   prdata = {25'd0, row_count_reg};
            trs_pkg::REG_RANDOM_SEED: prdata = seed_reg;
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mode_reg  <= 1'b0;
            run_count_reg <= '0;
            row_count_reg <= 7'd1;
            seed_reg      <= 32'd1;
        end
        else if (cfg_wr)
        begin
            unique case (trs_pkg::reg_idx_t'(paddr[3:2]))
                trs_pkg::REG_RUN_MODE:    run_mode_reg  <= pwdata[0];
                trs_pkg::REG_RUN_COUNT:   run_count_reg <= pwdata;
                trs_pkg::REG_ROW_COUNT:   row_count_reg <= pwdata[6:0];
                trs_pkg::REG_RANDOM_SEED: seed_reg      <= pwdata;
                default:                  run_mode_reg  <= run_mode_reg;
            endcase
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign wr_row.time_low    = req.payload.time_low;
    assign wr_row.time_high   = req.payload.time_high;
    assign wr_row.relay_modes = req.payload.relay_modes;
    assign wr_row.time_mode   = req.payload.time_mode;
    assign wr_row.chances     = {req.payload.chance_4, req.payload.chance_3,
                                 req.payload.chance_2, req.payload.chance_1,
                                 req.payload.chance_0};
    assign mem_wr = req_fire && (trs_pkg::cmd_t'(req.payload.command) == trs_pkg::CMD_LOAD)
                    && (status_reg == trs_pkg::ST_STOPPED)
                    && (32'(req.payload.row_index) < 32'(MAX_ROWS));

    trs_row_store #(.MAX_ROWS(MAX_ROWS), .ADDR_W(ADDR_W)) u_store
    (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (ADDR_W'(req.payload.row_index)),
        .wr_data (wr_row),
        .rd_addr (row_sel_reg),
        .rd_data (row)
    );

    always_comb
    begin
        if (row_count_reg == 7'd0)
        begin
            rows_use = 32'd1;
        end
        else if (32'(row_count_reg) > 32'(MAX_ROWS))
        begin
            rows_use = 32'(MAX_ROWS);
        end
        else
        begin
            rows_use = 32'(row_count_reg);
        end
    end

    assign next_row = {1'b0, active_reg} + (ADDR_W+1)'(1);
    assign pass_inc = pass_reg + 32'd1;
    assign cur_mode = row.relay_modes[2*z_reg +: 2];
    assign draw     = trs_pkg::lfsr_step(lfsr_reg);
    assign hi_eff   = (row.time_high < row.time_low) ? row.time_low : row.time_high;

    assign mod_start    = ((state_reg == S_RELAY)
                           && (trs_pkg::relay_mode_t'(cur_mode) == trs_pkg::RM_RANDOM))
                          || ((state_reg == S_TIME) && row.time_mode);
    assign mod_dividend = draw;
    assign mod_divisor  = (state_reg == S_TIME)
                          ? 33'({1'b0, hi_eff} - {1'b0, row.time_low} + 33'd1)
                          : trs_pkg::CHANCE_SPAN;

    trs_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            status_reg    <= trs_pkg::ST_STOPPED;
            relay_reg     <= '0;
            active_reg    <= '0;
            row_sel_reg   <= '0;
            pass_reg      <= '0;
            wait_reg      <= '0;
            lfsr_reg      <= 32'd1;
            z_reg         <= '0;
            started_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && (state_reg != S_FINISH))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    started_reg <= 1'b0;
                    if (req_fire)
                    begin
                        state_reg <= S_FINISH;
                        unique case (trs_pkg::cmd_t'(req.payload.command))
                            trs_pkg::CMD_START:
                            begin
                                if (status_reg == trs_pkg::ST_STOPPED)
                                begin
                                    lfsr_reg    <= (seed_reg != 32'd0) ? seed_reg : 32'd1;
                                    pass_reg    <= '0;
                                    status_reg  <= trs_pkg::ST_RUNNING;
                                    row_sel_reg <= '0;
                                    state_reg   <= S_READ;
                                end
                            end
                            trs_pkg::CMD_TICK:
                            begin
                                if (status_reg == trs_pkg::ST_RUNNING)
                                begin
                                    if (wait_reg > 32'd1)
                                    begin
                                        wait_reg <= wait_reg - 32'd1;
                                    end
                                    else
                                    begin
                                        state_reg <= S_ADVANCE;
                                    end
                                end
                            end
                            trs_pkg::CMD_PAUSE:
                            begin
                                if (status_reg == trs_pkg::ST_RUNNING)
                                begin
                                    status_reg <= trs_pkg::ST_PAUSED;
                                end
                                else if (status_reg == trs_pkg::ST_PAUSED)
                                begin
                                    status_reg <= trs_pkg::ST_RUNNING;
                                    state_reg  <= S_ADVANCE;
                                end
                            end
                            trs_pkg::CMD_STOP:
                            begin
                                if (status_reg != trs_pkg::ST_STOPPED)
                                begin
                                    status_reg <= trs_pkg::ST_STOPPED;
                                    wait_reg   <= '0;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_ADVANCE:
                begin
                    if (32'(next_row) >= rows_use)
                    begin
                        pass_reg <= pass_inc;
                        if (!run_mode_reg && (pass_inc >= run_count_reg))
                        begin
                            status_reg <= trs_pkg::ST_STOPPED;
                            wait_reg   <= '0;
                            state_reg  <= S_FINISH;
                        end
                        else
                        begin
                            row_sel_reg <= '0;
                            state_reg   <= S_READ;
                        end
                    end
                    else
                    begin
                        row_sel_reg <= ADDR_W'(next_row);
                        state_reg   <= S_READ;
                    end
                end
                S_READ:
                begin
                    z_reg     <= '0;
                    state_reg <= S_RELAY;
                end
                S_RELAY:
                begin
                    unique case (trs_pkg::relay_mode_t'(cur_mode))
                        trs_pkg::RM_ON:        relay_reg[z_reg] <= 1'b1;
                        trs_pkg::RM_OFF:       relay_reg[z_reg] <= 1'b0;
                        trs_pkg::RM_RANDOM:    lfsr_reg         <= draw;
                        trs_pkg::RM_UNCHANGED: relay_reg[z_reg] <= relay_reg[z_reg];
                        default:               relay_reg[z_reg] <= relay_reg[z_reg];
                    endcase
                    if (trs_pkg::relay_mode_t'(cur_mode) == trs_pkg::RM_RANDOM)
                    begin
                        state_reg <= S_WAIT_R;
                    end
                    else if (32'(z_reg) == 32'(RELAY_COUNT - 1))
                    begin
                        state_reg <= S_TIME;
                    end
                    else
                    begin
                        z_reg <= z_reg + ZW'(1);
                    end
                end
                S_WAIT_R:
                begin
                    if (mod_done)
                    begin
                        relay_reg[z_reg] <= (32'(mod_rem) <= 32'(row.chances[z_reg]));
                        if (32'(z_reg) == 32'(RELAY_COUNT - 1))
                        begin
                            state_reg <= S_TIME;
                        end
                        else
                        begin
                            z_reg     <= z_reg + ZW'(1);
                            state_reg <= S_RELAY;
                        end
                    end
                end
                S_TIME:
                begin
                    if (row.time_mode)
                    begin
                        lfsr_reg  <= draw;
                        state_reg <= S_WAIT_T;
                    end
                    else
                    begin
                        wait_reg    <= row.time_low;
                        active_reg  <= row_sel_reg;
                        started_reg <= 1'b1;
                        state_reg   <= S_FINISH;
                    end
                end
                S_WAIT_T:
                begin
                    if (mod_done)
                    begin
                        wait_reg    <= row.time_low + mod_rem;
                        active_reg  <= row_sel_reg;
                        started_reg <= 1'b1;
                        state_reg   <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg        <= 1'b1;
                        rsp_reg.relay_levels <= trs_pkg::RELAY_MAX'(relay_reg);
                        rsp_reg.status       <= status_reg;
                        rsp_reg.row_number   <= 6'(active_reg);
                        rsp_reg.run_number   <= pass_reg;
                        rsp_reg.row_started  <= started_reg;
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;
endmodule

FILE: hw/rtl/trs_mod_unit.sv
// Bit-serial remainder unit: one restoring step per cycle, 32 steps.
// Standalone; used by the sequencer for chance and dwell draws.
module trs_mod_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [31:0] remainder
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dq_reg, dq_next;
    logic [32:0] div_reg, div_next;
    logic [33:0] trial;

    assign trial = {rem_reg, dq_reg[31]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = 33'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[32:0];
            end
            dq_next  = dq_reg << 1;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[31:0];
endmodule

FILE: hw/rtl/trs_row_store.sv
// Schedule row memory: one write port, one registered read port.
// Depends on trs_pkg for the row layout.
module trs_row_store
#(
    parameter int MAX_ROWS = trs_pkg::MAX_ROWS_DEF,
    parameter int ADDR_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  trs_pkg::row_t     wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output trs_pkg::row_t     rd_data
);
    trs_pkg::row_t mem [MAX_ROWS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: hw/rtl/trs_checker.sv
// Port-level checks for the relay sequencer, bound to the top level.
// Depends on trs_pkg for status codes.
module trs_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input trs_pkg::rsp_t rsp_payload
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    a_started_running: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_payload.row_started |->
            rsp_payload.status == trs_pkg::ST_RUNNING)
        else $error("row applied while not running");
endmodule

bind timed_relay_sequencer trs_checker u_trs_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);
